FILE: rtl/epog_pkg.sv
// Package: shared types, constants and tables for the EPCA objective/gradient engine.
`timescale 1ns / 1ps
package epog_pkg;

  // Store geometry
  localparam int MAX_ROWS  = 256;
  localparam int MAX_COLS  = 256;
  localparam int MAX_RANK  = 16;
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int RANK_W    = $clog2(MAX_RANK);
  localparam int ADDR_W    = ROW_W + RANK_W;
  localparam int FAC_DEPTH = MAX_ROWS * MAX_RANK;
  localparam int ERANK_W   = RANK_W + 1;

  // Data widths (Q16.16 factors, 48-bit accumulators)
  localparam int FAC_W = 32;
  localparam int ACC_W = 48;

  // Exponential constants (Q16.16)
  localparam int LN2_Q16      = 45426;
  localparam int LN2_RECIP    = 94548;  // floor(2^32 / LN2_Q16)
  localparam int EXP_TOP_ARG  = 22 * 65536;
  localparam int EXP_BOT_ARG  = -20 * 65536;
  localparam int EXP_OFFSET   = 64 * LN2_Q16;
  localparam int EXP_Q_SPLIT  = 64 + 14;
  localparam int TAYLOR_TERMS = 12;

  // Request codes
  typedef enum logic [2:0] {
    REQ_WR_W     = 3'd0,
    REQ_WR_H     = 3'd1,
    REQ_SCORE    = 3'd2,
    REQ_RD_DW    = 3'd3,
    REQ_RD_DH    = 3'd4,
    REQ_RD_OBJ   = 3'd5,
    REQ_CLR_GRAD = 3'd6,
    REQ_NOP      = 3'd7
  } req_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_MODE = 2'd0,
    CFG_GW   = 2'd1,
    CFG_GH   = 2'd2,
    CFG_RANK = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    req_t               req_type;
    logic [7:0]         row_index;
    logic [7:0]         col_index;
    logic [3:0]         rank_index;
    logic signed [31:0] data_value;
    logic               present;
  } in_data_t;

  typedef struct packed {
    logic signed [47:0] result_value;
    logic               saturated;
    logic               status;
  } out_data_t;

  typedef struct packed {
    logic       normal_mode;
    logic       grad_w_en;
    logic       grad_h_en;
    logic [4:0] rank;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic              load_req;
    logic              clr_en;
    logic [ADDR_W-1:0] clr_addr;
    logic [RANK_W-1:0] k;
    logic              dot_issue;
    logic              grad_issue;
    logic              grad_rd;
    logic              fac_wr;
    logic              av_clr;
    logic              av_clamp;
    logic              prod_x;
    logic              exp_start;
    logic              obj_upd;
    logic              flag_clr;
    logic              out_load;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    req_t               req_type;
    logic [ERANK_W-1:0] eff_rank;
    logic               normal_mode;
    logic               grad_any;
    logic               pipe_busy;
    logic               exp_busy;
    logic               exp_done;
    logic               out_free;
  } ctrl_sts_t;

  // floor(2^32 / i); divisor one uses 2^32-1 and is fixed by the correction step
  function automatic logic [31:0] recip(input logic [3:0] i);
    logic [31:0] m;
    case (i)
      4'd2:    m = 32'h8000_0000;
      4'd3:    m = 32'h5555_5555;
      4'd4:    m = 32'h4000_0000;
      4'd5:    m = 32'h3333_3333;
      4'd6:    m = 32'h2AAA_AAAA;
      4'd7:    m = 32'h2492_4924;
      4'd8:    m = 32'h2000_0000;
      4'd9:    m = 32'h1C71_C71C;
      4'd10:   m = 32'h1999_9999;
      4'd11:   m = 32'h1745_D174;
      4'd12:   m = 32'h1555_5555;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

FILE: rtl/epog_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module epog_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/epog_exp.sv
// Iterative fixed-point exponential: range reduction by ln2, 12-term Taylor series, scaling.
`timescale 1ns / 1ps
module epog_exp (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] arg,
  output logic [31:0] res,
  output logic        sat,
  output logic        busy,
  output logic        done
);
  import epog_pkg::*;

  typedef enum logic [7:0] {
    E_IDLE = 8'b0000_0001,
    E_CHK  = 8'b0000_0010,
    E_DIV  = 8'b0000_0100,
    E_M1   = 8'b0000_1000,
    E_M2   = 8'b0001_0000,
    E_M3   = 8'b0010_0000,
    E_SCL  = 8'b0100_0000,
    E_DONE = 8'b1000_0000
  } exp_state_t;

  exp_state_t  st_r, st_nxt;
  logic [31:0] arg_r;
  logic [22:0] rem_r;
  logic [6:0]  q_r;
  logic [3:0]  i_r;
  logic [30:0] term_r;
  logic [31:0] sum_r;
  logic [60:0] prod_r;
  logic [30:0] p_r;
  logic [62:0] pm_r;
  logic [31:0] res_r;
  logic        sat_r;

  logic [32:0] off_full;
  logic [39:0] qm;
  logic [22:0] rem_c;
  logic [29:0] rr;
  logic [30:0] q0;
  logic [34:0] q0i;
  logic [34:0] rem2;
  logic [30:0] qv;
  logic [4:0]  sh;
  logic [5:0]  sr;
  logic [49:0] vw;

  // Combinational helpers for each step
  always_comb begin
    off_full = 33'($signed(arg_r)) + 33'(EXP_OFFSET);
    // quotient estimate by reciprocal, at most one low
    qm       = 40'(off_full[22:0]) * 40'(LN2_RECIP);
    rem_c    = rem_r - 23'(q_r) * 23'(LN2_Q16);
    rr       = {rem_r[15:0], 14'b0};
    q0       = pm_r[62:32];
    q0i      = 35'(q0) * 35'(i_r);
    rem2     = 35'(p_r) - q0i;
    qv       = (rem2 >= 35'(i_r)) ? q0 + 31'd1 : q0;
    sh       = 5'(q_r - 7'(EXP_Q_SPLIT));
    sr       = 6'(7'(EXP_Q_SPLIT) - q_r);
    if (q_r >= 7'(EXP_Q_SPLIT)) begin
      vw = 50'(sum_r) << sh;
    end else begin
      vw = (50'(sum_r) + (50'd1 << (sr - 6'd1))) >> sr;
    end
  end

  // Sequencer
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      E_IDLE:  if (start) st_nxt = E_CHK;
      E_CHK: begin
        if ($signed(arg_r) > 32'(EXP_TOP_ARG) || $signed(arg_r) < 32'(EXP_BOT_ARG)) begin
          st_nxt = E_DONE;
        end else begin
          st_nxt = E_DIV;
        end
      end
      E_DIV:   st_nxt = E_M1;
      E_M1:    st_nxt = E_M2;
      E_M2:    st_nxt = E_M3;
      E_M3:    st_nxt = (i_r == 4'(TAYLOR_TERMS)) ? E_SCL : E_M1;
      E_SCL:   st_nxt = E_DONE;
      E_DONE:  st_nxt = E_IDLE;
      default: st_nxt = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= E_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (st_r)
      E_IDLE: begin
        if (start) arg_r <= arg;
      end
      E_CHK: begin
        sat_r <= 1'b0;
        if ($signed(arg_r) > 32'(EXP_TOP_ARG)) begin
          res_r <= 32'h7FFF_FFFF;
          sat_r <= 1'b1;
        end else if ($signed(arg_r) < 32'(EXP_BOT_ARG)) begin
          res_r <= '0;
        end
        rem_r <= off_full[22:0];
        q_r   <= qm[38:32];
      end
      E_DIV: begin
        // remainder of the estimate, then one correction step
        if (rem_c >= 23'(LN2_Q16)) begin
          rem_r <= rem_c - 23'(LN2_Q16);
          q_r   <= q_r + 7'd1;
        end else begin
          rem_r <= rem_c;
        end
        term_r <= 31'h4000_0000;
        sum_r  <= 32'h4000_0000;
        i_r    <= 4'd1;
      end
      E_M1: prod_r <= 61'(term_r) * 61'(rr);
      E_M2: begin
        p_r  <= prod_r[60:30];
        pm_r <= 63'(prod_r[60:30]) * 63'(recip(i_r));
      end
      E_M3: begin
        term_r <= qv;
        sum_r  <= sum_r + 32'(qv);
        i_r    <= i_r + 4'd1;
      end
      E_SCL: begin
        if (vw > 50'h7FFF_FFFF) begin
          res_r <= 32'h7FFF_FFFF;
          sat_r <= 1'b1;
        end else begin
          res_r <= vw[31:0];
        end
      end
      default: ;
    endcase
  end

  assign res  = res_r;
  assign sat  = sat_r;
  assign busy = (st_r != E_IDLE);
  assign done = (st_r == E_DONE);

endmodule

FILE: rtl/epog_dp.sv
// Datapath: factor and gradient memories, dot-product and gradient pipelines, accumulators.
`timescale 1ns / 1ps
module epog_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  epog_pkg::cfg_t       cfg,
  input  epog_pkg::in_data_t   in_data,
  input  epog_pkg::ctrl_cmd_t  cmd,
  output epog_pkg::ctrl_sts_t  sts,
  output logic                 out_valid,
  input  logic                 out_ready,
  output epog_pkg::out_data_t  out_data
);
  import epog_pkg::*;

  // Saturate a 50-bit sum to 48 bits; top bit of the result is the clamp flag
  function automatic logic [ACC_W:0] sat_acc(input logic [ACC_W+1:0] v);
    logic [ACC_W:0] r;
    if (v[ACC_W+1:ACC_W-1] == 3'b000 || v[ACC_W+1:ACC_W-1] == 3'b111) begin
      r = {1'b0, v[ACC_W-1:0]};
    end else if (v[ACC_W+1]) begin
      r = {2'b11, {(ACC_W-1){1'b0}}};
    end else begin
      r = {2'b10, {(ACC_W-1){1'b1}}};
    end
    return r;
  endfunction

  in_data_t           req_r;
  logic [ERANK_W-1:0] eff_rank;
  logic               rank_bad;
  logic [RANK_W-1:0]  kk;
  logic [ADDR_W-1:0]  row_addr, col_addr;

  logic [FAC_W-1:0] w_rdata, h_rdata;
  logic [ACC_W-1:0] dw_rdata, dh_rdata;
  logic             w_we, h_we, fac_re, grad_re, dw_we, dh_we;
  logic [ADDR_W-1:0] dw_waddr, dh_waddr;
  logic [ACC_W-1:0]  dw_wdata, dh_wdata;

  logic               dv1_r, dv2_r;
  logic signed [63:0] dprod_r;
  logic [51:0]        av_acc_r;
  logic               av_ovf;
  logic signed [31:0] av_r;
  logic signed [63:0] xprod_r, sq_r;

  logic [31:0] exp_res;
  logic        exp_sat, exp_busy, exp_done;

  logic [47:0]        xav;
  logic [49:0]        sub;
  logic [49:0]        obj_sum;
  logic [ACC_W:0]     obj_sat;
  logic [ACC_W-1:0]   obj_r;
  logic signed [32:0] g_r;

  logic               gv1_r, gv2_r;
  logic [RANK_W-1:0]  gk1_r, gk2_r;
  logic signed [64:0] gh_full, gw_full;
  logic [48:0]        gh_r, gw_r;
  logic [ACC_W-1:0]   dwold_r, dhold_r;
  logic [ACC_W:0]     dw_sat, dh_sat;

  logic      flag_r, flag_nxt;
  logic      out_valid_r;
  out_data_t out_data_r;

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.load_req) req_r <= in_data;
  end

  // Effective rank and index check
  always_comb begin
    if (cfg.rank == '0) begin
      eff_rank = ERANK_W'(1);
    end else if (cfg.rank > 5'(MAX_RANK)) begin
      eff_rank = ERANK_W'(MAX_RANK);
    end else begin
      eff_rank = ERANK_W'(cfg.rank);
    end
  end
  assign rank_bad = (ERANK_W'(req_r.rank_index) >= eff_rank);

  // Memory addressing
  assign kk       = (cmd.dot_issue || cmd.grad_issue) ? cmd.k : req_r.rank_index;
  assign row_addr = {req_r.row_index, kk};
  assign col_addr = {req_r.col_index, kk};
  assign fac_re   = cmd.dot_issue | cmd.grad_issue;
  assign grad_re  = cmd.grad_issue | cmd.grad_rd;
  assign w_we     = cmd.fac_wr && (req_r.req_type == REQ_WR_W) && !rank_bad;
  assign h_we     = cmd.fac_wr && (req_r.req_type == REQ_WR_H) && !rank_bad;

  epog_ram #(.WIDTH(FAC_W), .DEPTH(FAC_DEPTH)) u_w_ram (
    .clk(clk), .we(w_we), .waddr(row_addr), .wdata(req_r.data_value),
    .re(fac_re), .raddr(row_addr), .rdata(w_rdata)
  );

  epog_ram #(.WIDTH(FAC_W), .DEPTH(FAC_DEPTH)) u_h_ram (
    .clk(clk), .we(h_we), .waddr(col_addr), .wdata(req_r.data_value),
    .re(fac_re), .raddr(col_addr), .rdata(h_rdata)
  );

  // Gradient writes: clearing pass or accumulate stage
  assign dw_we    = cmd.clr_en | (gv2_r & cfg.grad_w_en);
  assign dh_we    = cmd.clr_en | (gv2_r & cfg.grad_h_en);
  assign dw_waddr = cmd.clr_en ? cmd.clr_addr : {req_r.row_index, gk2_r};
  assign dh_waddr = cmd.clr_en ? cmd.clr_addr : {req_r.col_index, gk2_r};
  assign dw_wdata = cmd.clr_en ? '0 : dw_sat[ACC_W-1:0];
  assign dh_wdata = cmd.clr_en ? '0 : dh_sat[ACC_W-1:0];

  epog_ram #(.WIDTH(ACC_W), .DEPTH(FAC_DEPTH)) u_dw_ram (
    .clk(clk), .we(dw_we), .waddr(dw_waddr), .wdata(dw_wdata),
    .re(grad_re), .raddr(row_addr), .rdata(dw_rdata)
  );

  epog_ram #(.WIDTH(ACC_W), .DEPTH(FAC_DEPTH)) u_dh_ram (
    .clk(clk), .we(dh_we), .waddr(dh_waddr), .wdata(dh_wdata),
    .re(grad_re), .raddr(col_addr), .rdata(dh_rdata)
  );

  // Dot-product pipeline: read, multiply, accumulate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv1_r <= 1'b0;
      dv2_r <= 1'b0;
      gv1_r <= 1'b0;
      gv2_r <= 1'b0;
    end else begin
      dv1_r <= cmd.dot_issue;
      dv2_r <= dv1_r;
      gv1_r <= cmd.grad_issue;
      gv2_r <= gv1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (dv1_r) dprod_r <= $signed(w_rdata) * $signed(h_rdata);
    if (cmd.av_clr) begin
      av_acc_r <= '0;
    end else if (dv2_r) begin
      av_acc_r <= av_acc_r + {{4{dprod_r[63]}}, dprod_r[63:16]};
    end
  end

  // Clamp the dot product to 32 bits
  assign av_ovf = !((&av_acc_r[51:31]) || !(|av_acc_r[51:31]));

  always_ff @(posedge clk) begin
    if (cmd.av_clamp) begin
      if (!av_ovf) begin
        av_r <= av_acc_r[31:0];
      end else if (av_acc_r[51]) begin
        av_r <= 32'sh8000_0000;
      end else begin
        av_r <= 32'sh7FFF_FFFF;
      end
    end
    if (cmd.prod_x) begin
      xprod_r <= req_r.data_value * av_r;
      sq_r    <= av_r * av_r;
    end
  end

  epog_exp u_exp (
    .clk(clk), .rst_n(rst_n), .start(cmd.exp_start), .arg(av_r),
    .res(exp_res), .sat(exp_sat), .busy(exp_busy), .done(exp_done)
  );

  // Objective update
  always_comb begin
    xav     = req_r.present ? xprod_r[63:16] : '0;
    sub     = cfg.normal_mode ? {4'b0, sq_r[62:17]} : {18'b0, exp_res};
    obj_sum = {{2{obj_r[ACC_W-1]}}, obj_r} + {{2{xav[47]}}, xav} - sub;
    obj_sat = sat_acc(obj_sum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obj_r <= '0;
    end else if (cmd.obj_upd) begin
      obj_r <= obj_sat[ACC_W-1:0];
    end else if (cmd.out_load && req_r.req_type == REQ_RD_OBJ) begin
      obj_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.obj_upd) begin
      g_r <= (req_r.present ? 33'(req_r.data_value) : 33'sd0) - $signed({1'b0, exp_res});
    end
  end

  // Gradient pipeline: products, then read-modify-write
  assign gh_full = g_r * $signed(h_rdata);
  assign gw_full = g_r * $signed(w_rdata);

  always_ff @(posedge clk) begin
    gk1_r <= cmd.k;
    gk2_r <= gk1_r;
    if (gv1_r) begin
      gh_r    <= gh_full[64:16];
      gw_r    <= gw_full[64:16];
      dwold_r <= dw_rdata;
      dhold_r <= dh_rdata;
    end
  end

  assign dw_sat = sat_acc({{2{dwold_r[ACC_W-1]}}, dwold_r} + {gh_r[48], gh_r});
  assign dh_sat = sat_acc({{2{dhold_r[ACC_W-1]}}, dhold_r} + {gw_r[48], gw_r});

  // Sticky saturation flag
  always_comb begin
    flag_nxt = flag_r;
    if (cmd.av_clamp && av_ovf) flag_nxt = 1'b1;
    if (cmd.obj_upd && (obj_sat[ACC_W] || (!cfg.normal_mode && exp_sat))) flag_nxt = 1'b1;
    if (gv2_r && cfg.grad_w_en && dw_sat[ACC_W]) flag_nxt = 1'b1;
    if (gv2_r && cfg.grad_h_en && dh_sat[ACC_W]) flag_nxt = 1'b1;
    if (cmd.flag_clr) flag_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r <= 1'b0;
    end else begin
      flag_r <= flag_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.saturated    <= flag_r;
      out_data_r.status       <= 1'b0;
      out_data_r.result_value <= '0;
      case (req_r.req_type)
        REQ_WR_W, REQ_WR_H: out_data_r.status <= rank_bad;
        REQ_SCORE, REQ_RD_OBJ: out_data_r.result_value <= obj_r;
        REQ_RD_DW: begin
          out_data_r.status <= rank_bad;
          if (!rank_bad) out_data_r.result_value <= dw_rdata;
        end
        REQ_RD_DH: begin
          out_data_r.status <= rank_bad;
          if (!rank_bad) out_data_r.result_value <= dh_rdata;
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Status to controller
  assign sts.req_type    = req_r.req_type;
  assign sts.eff_rank    = eff_rank;
  assign sts.normal_mode = cfg.normal_mode;
  assign sts.grad_any    = cfg.grad_w_en | cfg.grad_h_en;
  assign sts.pipe_busy   = dv1_r | dv2_r | gv1_r | gv2_r;
  assign sts.exp_busy    = exp_busy;
  assign sts.exp_done    = exp_done;
  assign sts.out_free    = !out_valid_r || out_ready;

endmodule

FILE: rtl/epog_ctrl.sv
// Controller: sequences clearing, factor access, scoring and gradient passes.
`timescale 1ns / 1ps
module epog_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  epog_pkg::ctrl_sts_t sts,
  output epog_pkg::ctrl_cmd_t cmd
);
  import epog_pkg::*;

  typedef enum logic [12:0] {
    S_CLR   = 13'b0_0000_0000_0001,
    S_IDLE  = 13'b0_0000_0000_0010,
    S_EXEC  = 13'b0_0000_0000_0100,
    S_DOT   = 13'b0_0000_0000_1000,
    S_DOTW  = 13'b0_0000_0001_0000,
    S_CLAMP = 13'b0_0000_0010_0000,
    S_MULX  = 13'b0_0000_0100_0000,
    S_EXPW  = 13'b0_0000_1000_0000,
    S_OBJ   = 13'b0_0001_0000_0000,
    S_GRAD  = 13'b0_0010_0000_0000,
    S_GRADW = 13'b0_0100_0000_0000,
    S_DONE  = 13'b0_1000_0000_0000,
    S_SPARE = 13'b1_0000_0000_0000
  } state_t;

  state_t            st_r, st_nxt;
  logic [RANK_W-1:0] k_r, k_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic              boot_r, boot_nxt;
  logic              k_last;

  assign k_last = ((ERANK_W'(k_r) + ERANK_W'(1)) == sts.eff_rank);

  // Next state and commands
  always_comb begin
    st_nxt      = st_r;
    k_nxt       = k_r;
    clr_cnt_nxt = clr_cnt_r;
    boot_nxt    = boot_r;
    cmd         = '0;
    cmd.k       = k_r;
    cmd.clr_addr = clr_cnt_r;
    in_ready    = 1'b0;
    case (st_r)
      S_CLR: begin
        cmd.clr_en  = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (&clr_cnt_r) begin
          st_nxt   = boot_r ? S_IDLE : S_DONE;
          boot_nxt = 1'b0;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          st_nxt       = S_EXEC;
        end
      end
      S_EXEC: begin
        st_nxt = S_DONE;
        case (sts.req_type)
          REQ_WR_W, REQ_WR_H:   cmd.fac_wr = 1'b1;
          REQ_RD_DW, REQ_RD_DH: cmd.grad_rd = 1'b1;
          REQ_SCORE: begin
            cmd.av_clr = 1'b1;
            k_nxt      = '0;
            st_nxt     = S_DOT;
          end
          REQ_CLR_GRAD: begin
            cmd.flag_clr = 1'b1;
            clr_cnt_nxt  = '0;
            st_nxt       = S_CLR;
          end
          default: ;
        endcase
      end
      S_DOT: begin
        cmd.dot_issue = 1'b1;
        k_nxt         = k_r + 1'b1;
        if (k_last) st_nxt = S_DOTW;
      end
      S_DOTW:  if (!sts.pipe_busy) st_nxt = S_CLAMP;
      S_CLAMP: begin
        cmd.av_clamp = 1'b1;
        st_nxt       = S_MULX;
      end
      S_MULX: begin
        cmd.prod_x = 1'b1;
        if (sts.normal_mode) begin
          st_nxt = S_OBJ;
        end else begin
          cmd.exp_start = 1'b1;
          st_nxt        = S_EXPW;
        end
      end
      S_EXPW:  if (sts.exp_done) st_nxt = S_OBJ;
      S_OBJ: begin
        cmd.obj_upd = 1'b1;
        k_nxt       = '0;
        st_nxt      = (!sts.normal_mode && sts.grad_any) ? S_GRAD : S_DONE;
      end
      S_GRAD: begin
        cmd.grad_issue = 1'b1;
        k_nxt          = k_r + 1'b1;
        if (k_last) st_nxt = S_GRADW;
      end
      S_GRADW: if (!sts.pipe_busy) st_nxt = S_DONE;
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          st_nxt       = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_CLR;
      k_r       <= '0;
      clr_cnt_r <= '0;
      boot_r    <= 1'b1;
    end else begin
      st_r      <= st_nxt;
      k_r       <= k_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      boot_r    <= boot_nxt;
    end
  end

  // Rank walk never runs past the configured rank
  a_k_in_rank: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DOT || st_r == S_GRAD) |-> (ERANK_W'(k_r) < sts.eff_rank))
    else $error("rank walk index beyond effective rank");

  // Clamp only after the dot-product pipeline has drained
  a_clamp_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_CLAMP) |-> !sts.pipe_busy)
    else $error("dot product clamped with pipeline still busy");

  // Exponential unit is idle when started
  a_exp_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exp_start |-> !sts.exp_busy)
    else $error("exponential started while busy");

  // A result is loaded only into a free output register
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("output register overwritten");

endmodule

FILE: rtl/epca_objective_gradient.sv
// Top level: configuration registers, controller and datapath of the EPCA objective engine.
//
//  channel  direction  handshake                  payload
//  in_      input      in_valid / in_ready        in_data  (epog_pkg::in_data_t)
//  out_     output     out_valid / out_ready      out_data (epog_pkg::out_data_t)
//  config   APB slave  psel/penable/pwrite/pready 32-bit registers at 4*index
//
//  Factor writes, reads and objective reads do not walk the rank. Scoring walks the rank
//  through the factor RAMs and, in poisson mode, then runs the iterative exponential,
//  which stops early when its argument is out of range. With gradients enabled, poisson
//  mode scoring walks the rank once more to update the gradient RAMs. One transaction
//  is in work at a time. After reset and after a gradient clear the block sweeps all 4096
//  addresses of the gradient RAMs with in_ready low. A stalled result sits in the output
//  register while the next transaction is accepted.
`timescale 1ns / 1ps
module epca_objective_gradient (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  epog_pkg::in_data_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output epog_pkg::out_data_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import epog_pkg::*;

  logic       mode_r, gw_r, gh_r;
  logic [4:0] rank_r;
  logic       cfg_wr;
  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  ctrl_sts_t  sts;

  // Configuration register writes
  assign cfg_wr = psel & penable & pwrite & pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      gw_r   <= 1'b0;
      gh_r   <= 1'b0;
      rank_r <= 5'(MAX_RANK);
    end else if (cfg_wr) begin
      case (cfg_idx_t'(paddr[3:2]))
        CFG_MODE: mode_r <= pwdata[0];
        CFG_GW:   gw_r   <= pwdata[0];
        CFG_GH:   gh_r   <= pwdata[0];
        CFG_RANK: rank_r <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (cfg_idx_t'(paddr[3:2]))
      CFG_MODE: prdata = {31'b0, mode_r};
      CFG_GW:   prdata = {31'b0, gw_r};
      CFG_GH:   prdata = {31'b0, gh_r};
      CFG_RANK: prdata = {27'b0, rank_r};
      default:  prdata = '0;
    endcase
  end

  assign cfg.normal_mode = mode_r;
  assign cfg.grad_w_en   = gw_r;
  assign cfg.grad_h_en   = gh_r;
  assign cfg.rank        = rank_r;

  epog_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .sts(sts), .cmd(cmd)
  );

  epog_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cfg(cfg), .in_data(in_data), .cmd(cmd), .sts(sts),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

endmodule
